// ===== hw/rtl/sdi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdi_pkg: shared types and constants of the SD card SPI start-up sequencer
// Phase codes, command bytes, register indexes and the state and result
// records passed between the sequencer modules.
// ----------------------------------------------------------------------------
package sdi_pkg;

    localparam int CntW = 5;
    localparam int ByteW = 8;
    localparam int PhaseW = 3;
    localparam int CfgIdxW = 2;

    // sequencer phases; codes six and seven behave as idle
    localparam logic [PhaseW-1:0] PH_IDLE   = 3'd0;
    localparam logic [PhaseW-1:0] PH_PRECLK = 3'd1;
    localparam logic [PhaseW-1:0] PH_CMD0   = 3'd2;
    localparam logic [PhaseW-1:0] PH_POLL0  = 3'd3;
    localparam logic [PhaseW-1:0] PH_CMD1   = 3'd4;
    localparam logic [PhaseW-1:0] PH_POLL1  = 3'd5;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PRECLOCK_BYTES   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RESET_POLL_LIMIT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_START_ATTEMPTS   = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_START_POLL_LIMIT = 2'd3;

    localparam logic [CntW-1:0] CFG_PRECLOCK_RST   = 5'd20;
    localparam logic [CntW-1:0] CFG_RESET_POLL_RST = 5'd16;
    localparam logic [CntW-1:0] CFG_ATTEMPTS_RST   = 5'd20;
    localparam logic [CntW-1:0] CFG_START_POLL_RST = 5'd10;

    localparam logic [ByteW-1:0] BYTE_IDLE     = 8'hFF;
    localparam logic [ByteW-1:0] CMD0_FIRST    = 8'h40;
    localparam logic [ByteW-1:0] CMD0_CRC      = 8'h95;
    localparam logic [ByteW-1:0] CMD1_FIRST    = 8'h41;
    localparam logic [ByteW-1:0] REPLY_IDLE    = 8'h01;
    localparam logic [ByteW-1:0] REPLY_READY   = 8'h00;
    localparam logic [CntW-1:0]  CMD_LEN       = 5'd6;

    localparam logic KIND_START = 1'b0;

    typedef struct packed {
        logic [CntW-1:0] preclock_bytes;
        logic [CntW-1:0] reset_poll_limit;
        logic [CntW-1:0] start_attempts;
        logic [CntW-1:0] start_poll_limit;
    } t_cfg;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [CntW-1:0]   byte_count;
        logic [CntW-1:0]   poll_count;
        logic [CntW-1:0]   attempt_count;
        logic              initialized;
    } t_state;

    typedef struct packed {
        logic             tx_request;
        logic [ByteW-1:0] tx_byte;
        logic             select_card;
        logic             done_res;
        logic [ByteW-1:0] answer;
        logic             card_ready;
    } t_result;

    // byte idx of CMD0 (is_cmd1 low) or CMD1 (is_cmd1 high)
    function automatic logic [ByteW-1:0] cmd_byte(input logic is_cmd1,
                                                  input logic [2:0] idx);
        logic [ByteW-1:0] b;
        b = 8'h00;
        unique case (idx)
            3'd0:    b = is_cmd1 ? CMD1_FIRST : CMD0_FIRST;
            3'd5:    b = is_cmd1 ? 8'h00 : CMD0_CRC;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sd_spi_init_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer: SD card SPI-mode start-up sequencer
// A transfer passes the input register, then the result register, before its
// result is valid. Throughput: one transfer per cycle while the output side
// takes results; the step logic between the two registers is combinational.
// Reset: synchronous active low; phase idle, counters zero, card not
// initialized, limits at their defaults, both register stages empty.
// ----------------------------------------------------------------------------
module sd_spi_init_sequencer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [sdi_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [sdi_pkg::CntW-1:0]    i_cfg_data,
    input  wire logic                        i_in_valid,
    output wire logic                        o_in_ready,
    input  wire logic                        i_kind,
    input  wire logic [sdi_pkg::ByteW-1:0]   i_rx_byte,
    output wire logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output wire logic                        o_tx_request,
    output wire logic [sdi_pkg::ByteW-1:0]   o_tx_byte,
    output wire logic                        o_select_card,
    output wire logic                        o_done_res,
    output wire logic [sdi_pkg::ByteW-1:0]   o_answer,
    output wire logic                        o_card_ready
);
    import sdi_pkg::*;

    t_cfg             cfg;
    t_state           r_state;
    t_state           n_state;
    t_result          n_result;
    t_result          r_result;
    logic             r_out_vld;
    logic             r_in_vld;
    logic             r_kind;
    logic [ByteW-1:0] r_rx_byte;
    logic             advance;

    sdi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sdi_step u_step (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_kind    (r_kind),
        .i_rx_byte (r_rx_byte),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // move the held item into the result register when it is free or draining
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind    <= i_kind;
            r_rx_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.byte_count    <= '0;
            r_state.poll_count    <= '0;
            r_state.attempt_count <= '0;
            r_state.initialized   <= 1'b0;
            r_out_vld             <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_tx_request  = r_result.tx_request;
    assign o_tx_byte     = r_result.tx_byte;
    assign o_select_card = r_result.select_card;
    assign o_done_res    = r_result.done_res;
    assign o_answer      = r_result.answer;
    assign o_card_ready  = r_result.card_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/sdi_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdi_cfg_regs: configuration registers
// Holds the preclock count and the poll and attempt limits.
// ----------------------------------------------------------------------------
module sdi_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [sdi_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [sdi_pkg::CntW-1:0]   i_cfg_data,
    output sdi_pkg::t_cfg                   o_cfg
);
    import sdi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preclock_bytes   <= CFG_PRECLOCK_RST;
            r_cfg.reset_poll_limit <= CFG_RESET_POLL_RST;
            r_cfg.start_attempts   <= CFG_ATTEMPTS_RST;
            r_cfg.start_poll_limit <= CFG_START_POLL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRECLOCK_BYTES:   r_cfg.preclock_bytes   <= i_cfg_data;
                CFG_RESET_POLL_LIMIT: r_cfg.reset_poll_limit <= i_cfg_data;
                CFG_START_ATTEMPTS:   r_cfg.start_attempts   <= i_cfg_data;
                CFG_START_POLL_LIMIT: r_cfg.start_poll_limit <= i_cfg_data;
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== hw/rtl/sdi_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdi_step: next-state and result logic for one transfer
// Decides the next byte, chip select and completion from the current phase,
// the counters and the byte just received.
// ----------------------------------------------------------------------------
module sdi_step (
    input  wire sdi_pkg::t_cfg            i_cfg,
    input  wire sdi_pkg::t_state          i_state,
    input  wire logic                     i_kind,
    input  wire logic [sdi_pkg::ByteW-1:0] i_rx_byte,
    output sdi_pkg::t_state               o_state,
    output sdi_pkg::t_result              o_result
);
    import sdi_pkg::*;

    logic [CntW-1:0] byte_inc;
    logic [CntW-1:0] poll_inc;
    logic [CntW-1:0] att_inc;
    t_state          nx;
    t_result         res;

    assign byte_inc = i_state.byte_count + 5'd1;
    assign poll_inc = i_state.poll_count + 5'd1;
    assign att_inc  = i_state.attempt_count + 5'd1;

    always_comb begin
        nx  = i_state;
        res = '0;
        if (i_kind == KIND_START) begin
            if (i_state.initialized) begin
                nx.phase     = PH_IDLE;
                res.done_res = 1'b1;
            end else begin
                nx.phase         = PH_PRECLK;
                nx.byte_count    = '0;
                nx.poll_count    = '0;
                nx.attempt_count = '0;
                res.tx_request   = 1'b1;
                res.tx_byte      = BYTE_IDLE;
            end
        end else begin
            unique case (i_state.phase)
                PH_PRECLK: begin
                    nx.byte_count  = byte_inc;
                    res.tx_request = 1'b1;
                    if (byte_inc < i_cfg.preclock_bytes) begin
                        res.tx_byte = BYTE_IDLE;
                    end else begin
                        nx.phase        = PH_CMD0;
                        nx.byte_count   = '0;
                        res.tx_byte     = CMD0_FIRST;
                        res.select_card = 1'b1;
                    end
                end
                PH_CMD0, PH_CMD1: begin
                    nx.byte_count   = byte_inc;
                    res.tx_request  = 1'b1;
                    res.select_card = 1'b1;
                    if (byte_inc < CMD_LEN) begin
                        res.tx_byte = cmd_byte(i_state.phase == PH_CMD1, byte_inc[2:0]);
                    end else begin
                        nx.phase      = (i_state.phase == PH_CMD0) ? PH_POLL0 : PH_POLL1;
                        nx.poll_count = '0;
                        res.tx_byte   = BYTE_IDLE;
                    end
                end
                PH_POLL0: begin
                    nx.poll_count = poll_inc;
                    if (i_rx_byte == BYTE_IDLE && poll_inc < i_cfg.reset_poll_limit) begin
                        res.tx_request  = 1'b1;
                        res.tx_byte     = BYTE_IDLE;
                        res.select_card = 1'b1;
                    end else if (i_rx_byte != REPLY_IDLE) begin
                        nx.phase     = PH_IDLE;
                        res.done_res = 1'b1;
                        res.answer   = i_rx_byte;
                    end else begin
                        nx.phase         = PH_CMD1;
                        nx.byte_count    = '0;
                        nx.attempt_count = '0;
                        res.tx_request   = 1'b1;
                        res.tx_byte      = CMD1_FIRST;
                        res.select_card  = 1'b1;
                    end
                end
                PH_POLL1: begin
                    nx.poll_count = poll_inc;
                    if (i_rx_byte == BYTE_IDLE && poll_inc < i_cfg.start_poll_limit) begin
                        res.tx_request  = 1'b1;
                        res.tx_byte     = BYTE_IDLE;
                        res.select_card = 1'b1;
                    end else begin
                        nx.attempt_count = att_inc;
                        if (i_rx_byte == REPLY_READY || att_inc >= i_cfg.start_attempts) begin
                            nx.phase       = PH_IDLE;
                            nx.initialized = 1'b1;
                            res.done_res   = 1'b1;
                            res.answer     = i_rx_byte;
                        end else begin
                            // retry CMD1
                            nx.phase        = PH_CMD1;
                            nx.byte_count   = '0;
                            res.tx_request  = 1'b1;
                            res.tx_byte     = CMD1_FIRST;
                            res.select_card = 1'b1;
                        end
                    end
                end
                default: begin
                    nx.phase = PH_IDLE;
                end
            endcase
        end
        res.card_ready = nx.initialized;
    end

    assign o_state  = nx;
    assign o_result = res;

endmodule
`default_nettype wire

// ===== test/sd_init_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_init_checker: result checker for the SD card SPI start-up sequencer
// Watches the register port and both channels, keeps its own copy of the
// sequencer state and limits, predicts the command for every input transfer
// and compares each output transfer field by field with the oldest
// prediction. Hands the count of pending predictions and of failures out.
// ----------------------------------------------------------------------------
module sd_init_checker
    import sdi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [CntW-1:0]    i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic               i_kind,
    input  wire logic [ByteW-1:0]   i_rx_byte,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic               i_tx_request,
    input  wire logic [ByteW-1:0]   i_tx_byte,
    input  wire logic               i_select_card,
    input  wire logic               i_done_res,
    input  wire logic [ByteW-1:0]   i_answer,
    input  wire logic               i_card_ready,
    output int                      o_pending,
    output int                      o_fail_count
);

    // argument bytes of both commands
    localparam logic [ByteW-1:0] CMD_ARG = 8'h00;

    t_cfg    limits;
    t_state  seq;
    t_result predicted_cmds[$];
    int      fail_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 100)
            $display("%0t checker: %s got %0h want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // one step of the start-up sequence for one input transfer
    task automatic advance_sequencer(input logic kind, input logic [ByteW-1:0] rx,
                                     output t_result r);
        r = '0;
        if (kind == KIND_START) begin
            if (seq.initialized) begin
                seq.phase = PH_IDLE;
                r.done_res = 1'b1;
            end else begin
                seq.phase = PH_PRECLK;
                seq.byte_count = '0;
                seq.poll_count = '0;
                seq.attempt_count = '0;
                r.tx_request = 1'b1;
                r.tx_byte = BYTE_IDLE;
            end
        end else begin
            case (seq.phase)
                PH_PRECLK: begin
                    seq.byte_count = seq.byte_count + 1'b1;
                    r.tx_request = 1'b1;
                    if (seq.byte_count < limits.preclock_bytes) begin
                        r.tx_byte = BYTE_IDLE;
                    end else begin
                        seq.phase = PH_CMD0;
                        seq.byte_count = '0;
                        r.tx_byte = CMD0_FIRST;
                        r.select_card = 1'b1;
                    end
                end
                PH_CMD0, PH_CMD1: begin
                    seq.byte_count = seq.byte_count + 1'b1;
                    r.tx_request = 1'b1;
                    r.select_card = 1'b1;
                    if (seq.byte_count < CMD_LEN) begin
                        // only CMD0 carries a real CRC in its last byte
                        r.tx_byte = (seq.phase == PH_CMD0 && seq.byte_count == CMD_LEN - 5'd1)
                                    ? CMD0_CRC : CMD_ARG;
                    end else begin
                        seq.phase = (seq.phase == PH_CMD0) ? PH_POLL0 : PH_POLL1;
                        seq.poll_count = '0;
                        r.tx_byte = BYTE_IDLE;
                    end
                end
                PH_POLL0: begin
                    seq.poll_count = seq.poll_count + 1'b1;
                    if (rx == BYTE_IDLE && seq.poll_count < limits.reset_poll_limit) begin
                        r.tx_request = 1'b1;
                        r.tx_byte = BYTE_IDLE;
                        r.select_card = 1'b1;
                    end else if (rx != REPLY_IDLE) begin
                        seq.phase = PH_IDLE;
                        r.done_res = 1'b1;
                        r.answer = rx;
                    end else begin
                        seq.phase = PH_CMD1;
                        seq.byte_count = '0;
                        seq.attempt_count = '0;
                        r.tx_request = 1'b1;
                        r.tx_byte = CMD1_FIRST;
                        r.select_card = 1'b1;
                    end
                end
                PH_POLL1: begin
                    seq.poll_count = seq.poll_count + 1'b1;
                    if (rx == BYTE_IDLE && seq.poll_count < limits.start_poll_limit) begin
                        r.tx_request = 1'b1;
                        r.tx_byte = BYTE_IDLE;
                        r.select_card = 1'b1;
                    end else begin
                        seq.attempt_count = seq.attempt_count + 1'b1;
                        if (rx == REPLY_READY || seq.attempt_count >= limits.start_attempts) begin
                            seq.initialized = 1'b1;
                            seq.phase = PH_IDLE;
                            r.done_res = 1'b1;
                            r.answer = rx;
                        end else begin
                            seq.phase = PH_CMD1;
                            seq.byte_count = '0;
                            r.tx_request = 1'b1;
                            r.tx_byte = CMD1_FIRST;
                            r.select_card = 1'b1;
                        end
                    end
                end
                default: seq.phase = PH_IDLE;
            endcase
        end
        r.card_ready = seq.initialized;
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            limits = {CFG_PRECLOCK_RST, CFG_RESET_POLL_RST, CFG_ATTEMPTS_RST,
                      CFG_START_POLL_RST};
            seq = '0;
            predicted_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRECLOCK_BYTES:   limits.preclock_bytes = i_cfg_data;
                    CFG_RESET_POLL_LIMIT: limits.reset_poll_limit = i_cfg_data;
                    CFG_START_ATTEMPTS:   limits.start_attempts = i_cfg_data;
                    CFG_START_POLL_LIMIT: limits.start_poll_limit = i_cfg_data;
                endcase
            end
            // compare before predicting, so a result cannot meet its own prediction
            if (i_out_valid && i_out_ready) begin
                got = {i_tx_request, i_tx_byte, i_select_card, i_done_res, i_answer,
                       i_card_ready};
                if (predicted_cmds.size() == 0) begin
                    report_mismatch("result with nothing expected", got, 0);
                end else begin
                    want = predicted_cmds.pop_front();
                    if (got.tx_request !== want.tx_request)
                        report_mismatch("tx_request", got.tx_request, want.tx_request);
                    if (got.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
                    if (got.select_card !== want.select_card)
                        report_mismatch("select_card", got.select_card, want.select_card);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.answer !== want.answer)
                        report_mismatch("answer", got.answer, want.answer);
                    if (got.card_ready !== want.card_ready)
                        report_mismatch("card_ready", got.card_ready, want.card_ready);
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_sequencer(i_kind, i_rx_byte, want);
                predicted_cmds.push_back(want);
            end
        end
        o_pending <= predicted_cmds.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the SD card SPI start-up sequencer
// Plays a card on the byte-exchange side: start requests, preclock and
// command exchanges with junk replies, then polls answered with idle bytes,
// the idle reply, the ready reply or errors. Sessions are mostly cut short
// by a fresh start so the card stays uninitialized; the last phase lets one
// complete. Limits change between phases, extremes included. Both sides
// idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import sdi_pkg::*;

    localparam logic KIND_XFER = 1'b1;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   PHASE_ITEMS = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = CFG_PRECLOCK_BYTES;
    logic [CntW-1:0]    i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = KIND_START;
    logic [ByteW-1:0]   i_rx_byte = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_tx_request;
    logic [ByteW-1:0]   o_tx_byte;
    logic               o_select_card;
    logic               o_done_res;
    logic [ByteW-1:0]   o_answer;
    logic               o_card_ready;

    int   pending;
    int   fail_count;
    int   items_sent = 0;
    int   idle_cycles = 0;
    bit   send_eager = 1'b0;
    t_cfg limits_now;

    sd_spi_init_sequencer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_tx_request (o_tx_request),
        .o_tx_byte    (o_tx_byte),
        .o_select_card(o_select_card),
        .o_done_res   (o_done_res),
        .o_answer     (o_answer),
        .o_card_ready (o_card_ready)
    );

    sd_init_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_tx_request (o_tx_request),
        .i_tx_byte    (o_tx_byte),
        .i_select_card(o_select_card),
        .i_done_res   (o_done_res),
        .i_answer     (o_answer),
        .i_card_ready (o_card_ready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    // a zero limit still sends one byte
    function automatic int at_least_one(input logic [CntW-1:0] v);
        return (v == 0) ? 1 : v;
    endfunction

    task automatic send_item(input logic kind, input logic [ByteW-1:0] rx);
        int gap;
        if (items_sent % 32 == 0)
            send_eager = 1'($urandom_range(0, 1));
        gap = send_eager ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // hold the write enable across back-to-back writes
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CntW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_limits(input logic [CntW-1:0] pre, input logic [CntW-1:0] rpl,
                                input logic [CntW-1:0] att, input logic [CntW-1:0] spl);
        write_reg(CFG_PRECLOCK_BYTES, pre);
        write_reg(CFG_RESET_POLL_LIMIT, rpl);
        write_reg(CFG_START_ATTEMPTS, att);
        write_reg(CFG_START_POLL_LIMIT, spl);
        i_cfg_we <= 1'b0;
        limits_now = {pre, rpl, att, spl};
    endtask

    // drop valid and wait until every predicted command has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one start-up attempt as seen from the card; without allow_init the
    // session stops just short of anything that would mark the card ready
    task automatic card_session(input bit allow_init, output bit inited);
        int pre_n, rpl_n, att_n, spl_n, k, a;
        logic [ByteW-1:0] reply;
        bit fin;
        inited = 1'b0;
        pre_n = at_least_one(limits_now.preclock_bytes);
        rpl_n = at_least_one(limits_now.reset_poll_limit);
        att_n = at_least_one(limits_now.start_attempts);
        spl_n = at_least_one(limits_now.start_poll_limit);
        send_item(KIND_START, 8'($urandom_range(0, 255)));
        // preclock and CMD0 bytes: whatever comes back is ignored
        repeat (pre_n + CMD_LEN) send_item(KIND_XFER, 8'($urandom_range(0, 255)));
        k = $urandom_range(0, rpl_n);
        repeat (k) send_item(KIND_XFER, BYTE_IDLE);
        if (k == rpl_n || $urandom_range(0, 9) == 0)
            return;
        reply = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 254)) : REPLY_IDLE;
        send_item(KIND_XFER, reply);
        if (reply != REPLY_IDLE)
            return;
        for (a = 1; a <= att_n; a++) begin
            if (!allow_init && $urandom_range(0, 4) == 0)
                return;
            repeat (CMD_LEN) send_item(KIND_XFER, 8'($urandom_range(0, 255)));
            k = $urandom_range(0, spl_n);
            if (k == spl_n) begin
                repeat (k - 1) send_item(KIND_XFER, BYTE_IDLE);
                reply = BYTE_IDLE;
            end else begin
                repeat (k) send_item(KIND_XFER, BYTE_IDLE);
                reply = ($urandom_range(0, 2) == 0) ? REPLY_READY
                                                     : 8'($urandom_range(1, 254));
            end
            fin = (reply == REPLY_READY) || (a == att_n);
            if (fin && !allow_init)
                return;
            send_item(KIND_XFER, reply);
            if (fin) begin
                inited = 1'b1;
                return;
            end
        end
    endtask

    task automatic run_phase(input logic [CntW-1:0] pre, input logic [CntW-1:0] rpl,
                             input logic [CntW-1:0] att, input logic [CntW-1:0] spl);
        int first;
        bit inited;
        apply_limits(pre, rpl, att, spl);
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS) card_session(1'b0, inited);
        drain_results();
    endtask

    initial begin : stimulus
        bit inited;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero limits behave as one
        apply_limits(5'd0, 5'd0, 5'd0, 5'd0);
        send_item(KIND_XFER, BYTE_IDLE);         // exchange while idle: ignored
        send_item(KIND_XFER, 8'h00);
        send_item(KIND_START, 8'h00);
        send_item(KIND_START, 8'hFF);            // restart while busy
        repeat (1 + CMD_LEN) send_item(KIND_XFER, 8'h5A);
        send_item(KIND_XFER, BYTE_IDLE);         // CMD0 poll gives up at once
        drain_results();

        run_phase(5'd1, 5'd1, 5'd1, 5'd1);
        run_phase(5'd31, 5'd31, 5'd31, 5'd31);
        run_phase(CFG_PRECLOCK_RST, CFG_RESET_POLL_RST, CFG_ATTEMPTS_RST,
                  CFG_START_POLL_RST);
        run_phase(5'($urandom_range(1, 6)), 5'($urandom_range(1, 6)),
                  5'($urandom_range(1, 6)), 5'($urandom_range(1, 6)));
        run_phase(5'($urandom_range(0, 4)), 5'($urandom_range(0, 4)),
                  5'($urandom_range(0, 4)), 5'($urandom_range(0, 4)));

        // finally let the card come up, then starts finish at once
        apply_limits(5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)),
                     5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)));
        inited = 1'b0;
        while (!inited) card_session(1'b1, inited);
        repeat (24) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        drain_results();

        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin : result_sink
        int gap, taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken % 32 == 0)
                eager = 1'($urandom_range(0, 1));
            gap = eager ? 0 : pick_gap();
            // long hold-off so the block backs up into its input
            if (taken % 400 == 150)
                gap = 80;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
hw/rtl/sdi_pkg.sv
hw/rtl/sdi_cfg_regs.sv
hw/rtl/sdi_step.sv
hw/rtl/sd_spi_init_sequencer.sv
test/sd_init_checker.sv
test/tb.sv
